@@ rtl/tape_machine_instruction_executor_assert.svh @@
// ----------------------------------------------------------------------------
// tape machine executor assertion macros
// shared property wrappers for the rtl assertion checks
// ----------------------------------------------------------------------------
`ifndef TAPE_MACHINE_INSTRUCTION_EXECUTOR_ASSERT_SVH
`define TAPE_MACHINE_INSTRUCTION_EXECUTOR_ASSERT_SVH

// same-cycle implication, off during reset
`define TMIE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tmie check failed");

// next-cycle implication, off during reset
`define TMIE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tmie check failed");

`endif

@@ rtl/tmie_pkg.sv @@
// ----------------------------------------------------------------------------
// tmie_pkg
// shared types and constants of the tape machine instruction executor
// ----------------------------------------------------------------------------
package tmie_pkg;

   localparam int unsigned TAPE_DEPTH_DEF    = 32768;
   localparam int unsigned PROGRAM_DEPTH_DEF = 4096;

   localparam int unsigned CELL_W   = 16;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned TARGET_W = 12;
   localparam int unsigned NEXT_W   = 12;
   localparam int unsigned BYTE_W   = 8;

   typedef enum logic [KIND_W-1:0] {
      KIND_INC   = 3'd0,
      KIND_DEC   = 3'd1,
      KIND_LEFT  = 3'd2,
      KIND_RIGHT = 3'd3,
      KIND_OUT   = 3'd4,
      KIND_IN    = 3'd5,
      KIND_OPEN  = 3'd6,
      KIND_CLOSE = 3'd7
   } kind_type;

endpackage

@@ rtl/tmie_tape.sv @@
// ----------------------------------------------------------------------------
// tmie_tape
// tape cell memory: one read and one write port, cleared after reset,
// last write forwarded onto the registered read data
// ----------------------------------------------------------------------------
module tmie_tape #(
   parameter int unsigned TAPE_DEPTH = tmie_pkg::TAPE_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              rd_en,
   input  logic [$clog2(TAPE_DEPTH)-1:0]     rd_addr,
   output logic [tmie_pkg::CELL_W-1:0]       rd_data,
   input  logic                              wr_en,
   input  logic [$clog2(TAPE_DEPTH)-1:0]     wr_addr,
   input  logic [tmie_pkg::CELL_W-1:0]       wr_data,
   output logic                              busy
);

   localparam int unsigned CP_W = $clog2(TAPE_DEPTH);

   logic [tmie_pkg::CELL_W-1:0] tape_mem [TAPE_DEPTH];
   logic [tmie_pkg::CELL_W-1:0] mem_q_ff;
   logic [CP_W-1:0]             rd_addr_ff;
   logic                        clearing_ff;
   logic [CP_W-1:0]             clr_addr_ff;
   logic                        fwd_valid_ff;
   logic [CP_W-1:0]             fwd_addr_ff;
   logic [tmie_pkg::CELL_W-1:0] fwd_data_ff;

   // clearing pass, one cell a cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clearing_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == CP_W'(TAPE_DEPTH - 1)) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         tape_mem[clr_addr_ff] <= '0;
      end else if (wr_en) begin
         tape_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         mem_q_ff   <= tape_mem[rd_addr];
         rd_addr_ff <= rd_addr;
      end
   end

   // latest write covers a read issued on the same edge
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_valid_ff <= 1'b0;
      end else if (wr_en && !clearing_ff) begin
         fwd_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && !clearing_ff) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_data = (fwd_valid_ff && (fwd_addr_ff == rd_addr_ff)) ? fwd_data_ff : mem_q_ff;
   assign busy    = clearing_ff;

endmodule

@@ rtl/tape_machine_instruction_executor.sv @@
// ----------------------------------------------------------------------------
// tape_machine_instruction_executor
// runs one tape machine instruction per word: cell read-modify-write,
// pointer moves, bracket jumps, byte input and output
// ----------------------------------------------------------------------------
// pipeline: an accepted word is held in the execute stage, then in the rsp registers
// throughput: one word per cycle while rsp_tready is high, set by the single
//   tape read-modify-write port, last write forwarded to a back-to-back same-cell read
// reset: synchronous; clears pointers, then a clearing pass zeroes the tape,
//   req_tready stays low until it ends
module tape_machine_instruction_executor #(
   parameter int unsigned TAPE_DEPTH    = tmie_pkg::TAPE_DEPTH_DEF,
   parameter int unsigned PROGRAM_DEPTH = tmie_pkg::PROGRAM_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // jump_target [11:0], in_value [27:12], zero [31:28]
   input  logic [2:0]  req_tuser,   // kind [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // next_ip [11:0], out_byte [19:12], zero [23:20]
   output logic [0:0]  rsp_tuser    // out_valid [0]
);

   localparam int unsigned CP_W   = $clog2(TAPE_DEPTH);
   localparam int unsigned IP_W   = $clog2(PROGRAM_DEPTH);
   localparam int unsigned RSH    = 24;
   localparam int unsigned RECIP  = ((1 << RSH) + PROGRAM_DEPTH - 1) / PROGRAM_DEPTH;
   localparam int unsigned PROD_W = tmie_pkg::TARGET_W + RSH + 1;
   localparam int unsigned Q_W    = tmie_pkg::TARGET_W + 1;

   // input word fields
   tmie_pkg::kind_type                req_kind;
   logic [tmie_pkg::TARGET_W-1:0]     req_target;
   logic [tmie_pkg::CELL_W-1:0]       req_value;
   logic                              req_fire;

   // pointers
   logic [CP_W-1:0]                   cp_ff;
   logic [CP_W-1:0]                   cp_in;
   logic [IP_W-1:0]                   ip_ff;
   logic [IP_W-1:0]                   ip_in;

   // execute stage
   logic                              s1_valid_ff;
   tmie_pkg::kind_type                s1_kind_ff;
   logic [tmie_pkg::CELL_W-1:0]       s1_value_ff;
   logic [tmie_pkg::TARGET_W-1:0]     s1_tgt_ff;
   logic [Q_W-1:0]                    s1_q_ff;
   logic [CP_W-1:0]                   s1_addr_ff;
   logic                              s1_adv;
   logic [PROD_W-1:0]                 tgt_prod;

   // tape port
   logic [tmie_pkg::CELL_W-1:0]       cell_data;
   logic                              tape_wr_en;
   logic [tmie_pkg::CELL_W-1:0]       tape_wr_data;
   logic                              tape_busy;

   // result
   logic [31:0]                       tgt_rem;
   logic [IP_W-1:0]                   tgt_after;
   logic [IP_W-1:0]                   ip_after;
   logic                              do_jump;
   logic [31:0]                       next_wide;
   logic                              out_vld_ff;
   logic [tmie_pkg::NEXT_W-1:0]       rsp_next_ff;
   logic                              rsp_flag_ff;
   logic [tmie_pkg::BYTE_W-1:0]       rsp_byte_ff;

   assign req_kind   = tmie_pkg::kind_type'(req_tuser);
   assign req_target = req_tdata[11:0];
   assign req_value  = req_tdata[27:12];

   assign s1_adv     = s1_valid_ff && (!out_vld_ff || rsp_tready);
   assign req_tready = !tape_busy && (!s1_valid_ff || s1_adv);
   assign req_fire   = req_tvalid && req_tready;

   // pointer moves resolve at accept so the next word reads the right cell
   always_comb begin
      cp_in = cp_ff;
      if (req_fire) begin
         case (req_kind)
            tmie_pkg::KIND_LEFT:
               cp_in = (cp_ff == '0) ? CP_W'(TAPE_DEPTH - 1) : cp_ff - 1'b1;
            tmie_pkg::KIND_RIGHT:
               cp_in = (cp_ff == CP_W'(TAPE_DEPTH - 1)) ? '0 : cp_ff + 1'b1;
            default:
               cp_in = cp_ff;
         endcase
      end
   end

   // quotient of jump target by program depth, via reciprocal
   assign tgt_prod = PROD_W'(req_target) * PROD_W'(RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         cp_ff       <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         cp_ff <= cp_in;
         if (req_fire) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_adv) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_kind_ff  <= req_kind;
         s1_value_ff <= req_value;
         s1_tgt_ff   <= req_target;
         s1_q_ff     <= tgt_prod[PROD_W-1:RSH];
         s1_addr_ff  <= cp_ff;
      end
   end

   tmie_tape #(
      .TAPE_DEPTH (TAPE_DEPTH)
   ) u_tape (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (req_fire),
      .rd_addr (cp_ff),
      .rd_data (cell_data),
      .wr_en   (tape_wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (tape_wr_data),
      .busy    (tape_busy)
   );

   // cell update
   always_comb begin
      tape_wr_en   = 1'b0;
      tape_wr_data = cell_data;
      case (s1_kind_ff)
         tmie_pkg::KIND_INC: begin
            tape_wr_en   = s1_adv;
            tape_wr_data = cell_data + 1'b1;
         end
         tmie_pkg::KIND_DEC: begin
            tape_wr_en   = s1_adv;
            tape_wr_data = cell_data - 1'b1;
         end
         tmie_pkg::KIND_IN: begin
            tape_wr_en   = s1_adv;
            tape_wr_data = s1_value_ff;
         end
         default: begin
            tape_wr_en   = 1'b0;
            tape_wr_data = cell_data;
         end
      endcase
   end

   // next instruction address
   assign tgt_rem   = 32'(s1_tgt_ff) - 32'(s1_q_ff) * 32'(PROGRAM_DEPTH);
   assign tgt_after = (tgt_rem == 32'(PROGRAM_DEPTH - 1)) ? '0 : IP_W'(tgt_rem + 32'd1);
   assign ip_after  = (ip_ff == IP_W'(PROGRAM_DEPTH - 1)) ? '0 : ip_ff + 1'b1;

   always_comb begin
      case (s1_kind_ff)
         tmie_pkg::KIND_OPEN:  do_jump = (cell_data == '0);
         tmie_pkg::KIND_CLOSE: do_jump = (cell_data != '0);
         default:              do_jump = 1'b0;
      endcase
   end

   assign ip_in     = do_jump ? tgt_after : ip_after;
   assign next_wide = 32'(ip_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         ip_ff      <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (s1_adv) begin
            ip_ff      <= ip_in;
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_next_ff <= next_wide[tmie_pkg::NEXT_W-1:0];
         rsp_flag_ff <= (s1_kind_ff == tmie_pkg::KIND_OUT);
         rsp_byte_ff <= (s1_kind_ff == tmie_pkg::KIND_OUT) ?
                        cell_data[tmie_pkg::BYTE_W-1:0] : '0;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {4'b0000, rsp_byte_ff, rsp_next_ff};
   assign rsp_tuser  = rsp_flag_ff;

`include "tape_machine_instruction_executor_assert.svh"

   // a cell is written only by the word leaving the execute stage
   `TMIE_ASSERT_SAME(a_write_on_advance, clock, reset, tape_wr_en, s1_valid_ff && s1_adv)

   // an accepted word is in the execute stage on the next cycle
   `TMIE_ASSERT_NEXT(a_accept_fills_stage, clock, reset, req_fire, s1_valid_ff)

   // once the tape is cleared the clearing pass never restarts
   `TMIE_ASSERT_NEXT(a_clear_stays_done, clock, reset, !tape_busy, !tape_busy)

endmodule
